@@ design/fpr_pkg.sv @@
// ----------------------------------------------------------------------------
// fpr_pkg
// Shared types and constants for the fixed polynomial residual block.
// ----------------------------------------------------------------------------
package fpr_pkg;

    // Sample width, fixed by the item format
    localparam int SAMPLE_BITS = 8;

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;
    typedef logic [1:0]                    t_order;

    // Predictor select codes
    localparam t_order ORDER_AVG = 2'd0;
    localparam t_order ORDER_1   = 2'd1;
    localparam t_order ORDER_2   = 2'd2;
    localparam t_order ORDER_3   = 2'd3;

    // History terms seen by the predictor, newest first, zero where missing
    typedef struct packed {
        t_sample s1;
        t_sample s2;
        t_sample s3;
    } t_terms;

endpackage

@@ design/fixed_polynomial_residual.sv @@
// ----------------------------------------------------------------------------
// fixed_polynomial_residual
// Path: an accepted sample is held in the input register, then passes
// through the predictor logic into the result register, from which it is taken.
// Throughput: one item per cycle while no stall is held; input register, then
// predictor logic into the result register, with stall passed back stage by stage.
// Reset: synchronous, active low; history and position cleared, order = 1.
// ----------------------------------------------------------------------------
module fixed_polynomial_residual (
    input  logic             i_clk,
    input  logic             i_rst_n,
    // configuration
    input  logic             i_cfg_wr_en,
    input  fpr_pkg::t_order  i_cfg_wr_data,
    // input items
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  fpr_pkg::t_sample i_sample,
    input  logic             i_block_start,
    // result items
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output fpr_pkg::t_sample o_residual
);
    import fpr_pkg::*;

    t_order  r_order;
    logic    r_in_valid;
    t_sample r_x;
    t_terms  r_terms;
    logic    r_out_valid;
    t_sample r_residual;

    logic    out_free;
    logic    in_accept;
    t_terms  terms;
    t_sample n_residual;

    // stage handshake
    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_in_valid && !out_free;
    assign in_accept  = i_in_valid && !o_in_stall;

    // order register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_order <= ORDER_1;
        end else if (i_cfg_wr_en) begin
            r_order <= i_cfg_wr_data;
        end
    end

    fpr_history u_history (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (in_accept),
        .i_sample      (i_sample),
        .i_block_start (i_block_start),
        .o_terms       (terms)
    );

    // input register: sample and its history terms
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_x     <= i_sample;
            r_terms <= terms;
        end
    end

    fpr_predict u_predict (
        .i_order    (r_order),
        .i_sample   (r_x),
        .i_terms    (r_terms),
        .o_residual (n_residual)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && r_in_valid) begin
            r_residual <= n_residual;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_residual  = r_residual;

endmodule

@@ design/fpr_history.sv @@
// ----------------------------------------------------------------------------
// fpr_history
// Holds the last three samples and the position in the block; gives the
// history terms for the item being accepted, with missing terms zeroed.
// ----------------------------------------------------------------------------
module fpr_history (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  fpr_pkg::t_sample i_sample,
    input  logic             i_block_start,
    output fpr_pkg::t_terms  o_terms
);
    import fpr_pkg::*;

    t_sample    r_hist [3];
    logic [1:0] r_position;
    logic [1:0] n_position;
    logic [1:0] pos;

    // block start discards earlier samples for this item
    assign pos = i_block_start ? 2'd0 : r_position;

    always_comb begin
        o_terms.s1 = (pos >= 2'd1) ? r_hist[0] : '0;
        o_terms.s2 = (pos >= 2'd2) ? r_hist[1] : '0;
        o_terms.s3 = (pos == 2'd3) ? r_hist[2] : '0;
    end

    // position saturates at three
    assign n_position = (pos == 2'd3) ? 2'd3 : pos + 2'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist[0]  <= '0;
            r_hist[1]  <= '0;
            r_hist[2]  <= '0;
            r_position <= 2'd0;
        end else if (i_accept) begin
            r_hist[2]  <= r_hist[1];
            r_hist[1]  <= r_hist[0];
            r_hist[0]  <= i_sample;
            r_position <= n_position;
        end
    end

endmodule

@@ design/fpr_predict.sv @@
// ----------------------------------------------------------------------------
// fpr_predict
// Forms the prediction for the selected order and the wrapped residual.
// ----------------------------------------------------------------------------
module fpr_predict (
    input  fpr_pkg::t_order  i_order,
    input  fpr_pkg::t_sample i_sample,
    input  fpr_pkg::t_terms  i_terms,
    output fpr_pkg::t_sample o_residual
);
    import fpr_pkg::*;

    t_sample half1;
    t_sample half2;
    t_sample pred;

    // halves truncated toward zero: bias negatives by one before the shift
    assign half1 = (i_terms.s1 + t_sample'(i_terms.s1[SAMPLE_BITS-1])) >>> 1;
    assign half2 = (i_terms.s2 + t_sample'(i_terms.s2[SAMPLE_BITS-1])) >>> 1;

    // prediction, all terms wrap at sample width
    always_comb begin
        unique case (i_order)
            ORDER_1: pred = i_terms.s1;
            ORDER_2: pred = (i_terms.s1 <<< 1) - i_terms.s2;
            ORDER_3: pred = i_terms.s1 + (i_terms.s1 <<< 1)
                          - i_terms.s2 - (i_terms.s2 <<< 1) + i_terms.s3;
            default: pred = half1 + half2;
        endcase
    end

    // average predictor takes the opposite sign convention
    assign o_residual = (i_order == ORDER_AVG) ? i_sample - pred : pred - i_sample;

endmodule
